// ----- design/assert_macros.svh -----
// Assertion macros shared by the heater PID on-time design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion lbl failed");
// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion lbl failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/hpot_pkg.sv -----
// Types and constants shared by the heater PID on-time design.
package hpot_pkg;

    localparam int TEMP_W    = 13;
    localparam int ERR_W     = TEMP_W + 1;
    localparam int DERR_W    = ERR_W + 1;
    localparam int SUM_W     = 32;
    localparam int GAIN_W    = 16;
    localparam int ON_TIME_W = 13;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [ERR_W-1:0] INTEG_STOP   = 14'sd500;
    localparam logic signed [ERR_W-1:0] DERIV_START  = 14'sd30;
    localparam logic signed [ERR_W-1:0] OVERSHOOT_LO = -14'sd20;
    localparam logic signed [ERR_W-1:0] BAND_HI      = 14'sd18;
    localparam logic signed [ERR_W-1:0] BAND_LO      = -14'sd18;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd15;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd2;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_GAIN_DERIV = 2'd2
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_HEAT = 2'd0,
        STATUS_COOL = 2'd1,
        STATUS_NEAR = 2'd2
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   isum;
        logic signed [DERR_W-1:0]  dterm;
    } err_stage_t;

endpackage

// ----- design/hpot_err_stage.sv -----
// Error, integral and derivative state update for each accepted transaction.
`include "assert_macros.svh"

module hpot_err_stage
    import hpot_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [TEMP_W-1:0]   measured_temp,
    input  logic [TEMP_W-1:0]   target_temp,
    output err_stage_t          stage_o
);

    logic signed [ERR_W-1:0]  prev_error_reg, prev_error_next;
    logic signed [SUM_W-1:0]  error_sum_reg, error_sum_next;

    logic signed [ERR_W-1:0]  err_w;
    logic signed [SUM_W:0]    sum_ext;
    logic signed [SUM_W-1:0]  sum_sat;
    logic signed [DERR_W-1:0] derr;
    logic                     integ_ok;
    logic                     overshoot;

    always_comb begin
        err_w     = $signed({1'b0, target_temp}) - $signed({1'b0, measured_temp});
        sum_ext   = {error_sum_reg[SUM_W-1], error_sum_reg}
                  + {{(SUM_W + 1 - ERR_W){err_w[ERR_W-1]}}, err_w};
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
        integ_ok  = err_w < INTEG_STOP;
        overshoot = err_w < OVERSHOOT_LO;
        derr      = {err_w[ERR_W-1], err_w} - {prev_error_reg[ERR_W-1], prev_error_reg};

        priority if (overshoot) begin
            error_sum_next = '0;
        end else if (integ_ok) begin
            error_sum_next = sum_sat;
        end else begin
            error_sum_next = error_sum_reg;
        end
        prev_error_next = err_w;

        priority if (err_w >= BAND_HI) begin
            stage_o.status = STATUS_HEAT;
        end else if (err_w < BAND_LO) begin
            stage_o.status = STATUS_COOL;
        end else begin
            stage_o.status = STATUS_NEAR;
        end
        stage_o.err   = err_w;
        stage_o.isum  = (integ_ok && !overshoot) ? sum_sat : '0;
        stage_o.dterm = (err_w > DERIV_START) ? derr : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
        end else if (accept) begin
            prev_error_reg <= prev_error_next;
            error_sum_reg  <= error_sum_next;
        end
    end

    `ASSERT_CLK(a_overshoot_clears, aclk, aresetn, (accept && overshoot) |=> (error_sum_reg == '0))
    `ASSERT_CLK(a_prev_tracks, aclk, aresetn, accept |=> (prev_error_reg == $past(err_w)))
    `ASSERT_CLK(a_hold_idle, aclk, aresetn, !accept |=> $stable(error_sum_reg))

endmodule

// ----- design/heater_pid_on_time.sv -----
// Heater on-time PID controller: three-stage pipeline with stream handshakes.
// Each stage holds one item with its own valid bit: state, multiply and sum, in that order.
// Throughput: one transaction per cycle unless m_tready back-pressure stalls the pipeline.
// The integral and previous-error state are updated in the cycle a transaction is accepted.
// Reset (aresetn low, synchronous) empties the pipeline, clears the state and loads the
// default gains 15, 2 and 1.
`include "assert_macros.svh"

module heater_pid_on_time
    import hpot_pkg::*;
#(
    parameter int unsigned OUT_LIMIT = 6000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // measured_temp [12:0], target_temp [25:13]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata    // heat_on_time [12:0], heat_status [14:13]
);

    localparam int PROP_W  = GAIN_W + 1 + ERR_W;
    localparam int INTEG_W = GAIN_W + 1 + SUM_W;
    localparam int DERIV_W = GAIN_W + 1 + DERR_W;
    localparam int TOTAL_W = INTEG_W + 1;
    localparam logic signed [TOTAL_W-1:0] LIMIT_W = TOTAL_W'(OUT_LIMIT);
    localparam logic [ON_TIME_W-1:0] ON_TIME_MAX = {ON_TIME_W{1'b1}};

    logic [GAIN_W-1:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic ready1, ready2, ready3;
    logic accept;

    err_stage_t stage_w, stage1_reg;

    logic signed [PROP_W-1:0]  prod_prop_reg, prod_prop_next;
    logic signed [INTEG_W-1:0] prod_integ_reg, prod_integ_next;
    logic signed [DERIV_W-1:0] prod_deriv_reg, prod_deriv_next;
    status_t                   status2_reg;

    logic signed [TOTAL_W-1:0] total_w;
    logic [ON_TIME_W-1:0]      on_time_reg, on_time_next;
    status_t                   status3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_integ_reg <= GAIN_INTEG_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GAIN_PROP:  gain_prop_reg  <= cfg_wdata;
                REG_GAIN_INTEG: gain_integ_reg <= cfg_wdata;
                REG_GAIN_DERIV: gain_deriv_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign accept   = s_tvalid && ready1;

    hpot_err_stage u_err_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .measured_temp (s_tdata[TEMP_W-1:0]),
        .target_temp   (s_tdata[2*TEMP_W-1:TEMP_W]),
        .stage_o       (stage_w)
    );

    always_comb begin
        prod_prop_next  = $signed({1'b0, gain_prop_reg})  * stage1_reg.err;
        prod_integ_next = $signed({1'b0, gain_integ_reg}) * stage1_reg.isum;
        prod_deriv_next = $signed({1'b0, gain_deriv_reg}) * stage1_reg.dterm;
    end

    always_comb begin
        total_w = {{(TOTAL_W - PROP_W){prod_prop_reg[PROP_W-1]}}, prod_prop_reg}
                + {prod_integ_reg[INTEG_W-1], prod_integ_reg}
                + {{(TOTAL_W - DERIV_W){prod_deriv_reg[DERIV_W-1]}}, prod_deriv_reg};
        priority if (total_w <= 0) begin
            on_time_next = '0;
        end else if (total_w > LIMIT_W) begin
            on_time_next = LIMIT_W[ON_TIME_W-1:0];
        end else begin
            on_time_next = total_w[ON_TIME_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            stage1_reg <= stage_w;
        end
        if (ready2) begin
            prod_prop_reg  <= prod_prop_next;
            prod_integ_reg <= prod_integ_next;
            prod_deriv_reg <= prod_deriv_next;
            status2_reg    <= stage1_reg.status;
        end
        if (ready3) begin
            on_time_reg <= on_time_next;
            status3_reg <= status2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {1'b0, status3_reg, on_time_reg};

    `ASSERT_CLK(a_stall_full, aclk, aresetn, !s_tready |-> (v1_reg && v2_reg && v3_reg))
    `ASSERT_CLK(a_stage_move, aclk, aresetn, (v1_reg && ready2) |=> v2_reg)
    `ASSERT_CLK(a_status_code, aclk, aresetn, m_tvalid |-> (status3_reg != 2'd3))
    `ASSERT_CLK(a_limit, aclk, aresetn, m_tvalid |-> ((OUT_LIMIT > ON_TIME_MAX) || (on_time_reg <= LIMIT_W[ON_TIME_W-1:0])))
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for heater_pid_on_time: directed table, random phases, gain sweeps.
`timescale 1ns / 1ps

module tb_top;
    import hpot_pkg::*;

    localparam int HEAT_LIMIT = 6000;
    localparam int PIPE_LAT = 3;
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [ON_TIME_W-1:0] on_time;
        status_t status;
    } heat_cmd_t;

    typedef struct packed {
        logic [TEMP_W-1:0] meas;
        logic [TEMP_W-1:0] targ;
        logic typed;
        logic [ON_TIME_W-1:0] on_time;
        status_t status;
    } temp_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [GAIN_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [15:0] m_tdata;

    heat_cmd_t heat_cmd_q[$];
    int err_cnt = 0;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;

    int kp_gain;
    int ki_gain;
    int kd_gain;
    logic signed [ERR_W-1:0] prev_err;
    logic signed [SUM_W-1:0] err_integral;

    temp_row_t dir_rows [0:18] = '{
        '{13'd0,    13'd0,    1'b1, 13'd0,    STATUS_NEAR},
        '{13'd8191, 13'd0,    1'b1, 13'd0,    STATUS_COOL},
        '{13'd0,    13'd8191, 1'b1, 13'd6000, STATUS_HEAT},
        '{13'd8191, 13'd8191, 1'b1, 13'd0,    STATUS_NEAR},
        '{13'd100,  13'd118,  1'b0, 13'd0,    STATUS_HEAT},
        '{13'd101,  13'd118,  1'b0, 13'd0,    STATUS_NEAR},
        '{13'd118,  13'd100,  1'b0, 13'd0,    STATUS_NEAR},
        '{13'd119,  13'd100,  1'b0, 13'd0,    STATUS_COOL},
        '{13'd120,  13'd100,  1'b0, 13'd0,    STATUS_COOL},
        '{13'd121,  13'd100,  1'b0, 13'd0,    STATUS_COOL},
        '{13'd1000, 13'd1499, 1'b0, 13'd0,    STATUS_HEAT},
        '{13'd1000, 13'd1500, 1'b0, 13'd0,    STATUS_HEAT},
        '{13'd1000, 13'd1030, 1'b0, 13'd0,    STATUS_HEAT},
        '{13'd1000, 13'd1031, 1'b0, 13'd0,    STATUS_HEAT},
        '{13'd5461, 13'd2730, 1'b0, 13'd0,    STATUS_COOL},
        '{13'd2730, 13'd5461, 1'b0, 13'd0,    STATUS_HEAT},
        '{13'd0,    13'd499,  1'b0, 13'd0,    STATUS_HEAT},
        '{13'd7000, 13'd6990, 1'b0, 13'd0,    STATUS_NEAR},
        '{13'd50,   13'd60,   1'b0, 13'd0,    STATUS_NEAR}
    };

    heater_pid_on_time #(
        .OUT_LIMIT(HEAT_LIMIT)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic heat_cmd_t predict_heat(input logic [TEMP_W-1:0] meas,
                                               input logic [TEMP_W-1:0] targ);
        logic signed [ERR_W-1:0] err;
        longint acc;
        longint isum;
        logic use_integ;
        heat_cmd_t r;
        err = ERR_W'({1'b0, targ}) - ERR_W'({1'b0, meas});
        if (err >= BAND_HI) begin
            r.status = STATUS_HEAT;
        end else if (err < BAND_LO) begin
            r.status = STATUS_COOL;
        end else begin
            r.status = STATUS_NEAR;
        end
        use_integ = 1'b0;
        if (err < INTEG_STOP) begin
            isum = longint'(err_integral) + longint'(err);
            if (isum > longint'(32'sh7FFF_FFFF)) isum = longint'(32'sh7FFF_FFFF);
            if (isum < -longint'(64'sd2147483648)) isum = -longint'(64'sd2147483648);
            err_integral = isum[SUM_W-1:0];
            use_integ = 1'b1;
        end
        if (err < OVERSHOOT_LO) begin
            err_integral = '0;
            use_integ = 1'b0;
        end
        acc = longint'(kp_gain) * longint'(err);
        if (use_integ) acc += longint'(ki_gain) * longint'(err_integral);
        if (err > DERIV_START) acc += longint'(kd_gain) * (longint'(err) - longint'(prev_err));
        prev_err = err;
        if (acc <= 0) begin
            acc = 0;
        end else if (acc > HEAT_LIMIT) begin
            acc = HEAT_LIMIT;
        end
        r.on_time = acc[ON_TIME_W-1:0];
        return r;
    endfunction

    task automatic push_temps(input logic [TEMP_W-1:0] meas, input logic [TEMP_W-1:0] targ,
                              input logic typed, input heat_cmd_t typed_cmd);
        int gap;
        heat_cmd_t cmd;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, targ, meas};
        do @(posedge aclk); while (!s_tready);
        cmd = predict_heat(meas, targ);
        heat_cmd_q.push_back(typed ? typed_cmd : cmd);
    endtask

    task automatic send_random_temps(input int count);
        logic [TEMP_W-1:0] meas;
        int t;
        for (int k = 0; k < count; k++) begin
            meas = TEMP_W'($urandom_range(0, 8191));
            if ($urandom_range(0, 9) < 3) begin
                t = $urandom_range(0, 8191);
            end else begin
                t = int'(meas) + int'($urandom_range(0, 580)) - 40;
                if (t < 0) t = 0;
                if (t > 8191) t = 8191;
            end
            push_temps(meas, t[TEMP_W-1:0], 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (heat_cmd_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        unique case (idx)
            REG_GAIN_PROP: kp_gain = int'(val);
            REG_GAIN_INTEG: ki_gain = int'(val);
            REG_GAIN_DERIV: kd_gain = int'(val);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] spare);
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_SPARE, spare);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            int stall;
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (heat_cmd_q.size() == 0) begin
                $error("unexpected transaction: heat_on_time=%0d heat_status=%0d",
                       m_tdata[12:0], m_tdata[14:13]);
                err_cnt++;
            end else begin
                heat_cmd_t exp_cmd;
                exp_cmd = heat_cmd_q.pop_front();
                if (m_tdata[12:0] !== exp_cmd.on_time) begin
                    $error("heat_on_time: expected %0d, got %0d", exp_cmd.on_time,
                           m_tdata[12:0]);
                    err_cnt++;
                end
                if (m_tdata[14:13] !== exp_cmd.status) begin
                    $error("heat_status: expected %0d, got %0d", exp_cmd.status,
                           m_tdata[14:13]);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        kp_gain = int'(GAIN_PROP_RST);
        ki_gain = int'(GAIN_INTEG_RST);
        kd_gain = int'(GAIN_DERIV_RST);
        prev_err = '0;
        err_integral = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[k]) begin
            push_temps(dir_rows[k].meas, dir_rows[k].targ, dir_rows[k].typed,
                       '{dir_rows[k].on_time, dir_rows[k].status});
        end
        send_random_temps(220);
        wait_idle();

        load_gains(16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_random_temps(150);
        wait_idle();

        // Saturated gains with back-to-back traffic; the long receiver hold-off fills the pipe.
        load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        no_idle = 1'b1;
        send_random_temps(60);
        hold_req = 1'b1;
        send_random_temps(140);
        no_idle = 1'b0;
        wait_idle();

        load_gains(GAIN_W'($urandom_range(1, 40)), GAIN_W'($urandom_range(0, 8)),
                   GAIN_W'($urandom_range(0, 20)), GAIN_W'($urandom_range(0, 65535)));
        send_random_temps(190);
        wait_idle();

        load_gains(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
                   GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)));
        send_random_temps(190);
        wait_idle();

        load_gains(GAIN_W'($urandom_range(1, 40)), GAIN_W'($urandom_range(0, 8)),
                   GAIN_W'($urandom_range(0, 20)), GAIN_W'($urandom_range(0, 65535)));
        send_random_temps(190);
        wait_idle();

        repeat (2 * PIPE_LAT) @(posedge aclk);
        if (heat_cmd_q.size() != 0) begin
            $error("%0d expected transactions never arrived", heat_cmd_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
